### design/epp_pkg.sv
// Package: item codes, queue entry type and pixel code table for the e-paper serial writer.
`default_nettype none
package epp_pkg;

    typedef enum logic [1:0] {
        CMD_COMMAND = 2'd0,
        CMD_DATA    = 2'd1,
        CMD_PIXEL   = 2'd2
    } t_cmd;

    localparam int unsigned BYTE_BITS  = 8;
    localparam int unsigned WORD_BITS  = 32;
    localparam int unsigned CNT_BITS   = $clog2(WORD_BITS);
    localparam int unsigned PIX_BITS   = 4;
    localparam int unsigned PIX_COUNT  = 8;

    localparam logic [PIX_BITS-1:0] PIX_BLACK = 4'h0;
    localparam logic [PIX_BITS-1:0] PIX_RED   = 4'h4;
    localparam logic [PIX_BITS-1:0] PIX_WHITE = 4'h3;

    localparam logic [CNT_BITS-1:0] CNT_BYTE_LAST = 5'd7;
    localparam logic [CNT_BITS-1:0] CNT_WORD_LAST = 5'd31;

    // One classified request: bits to shift, msb first.
    typedef struct packed {
        logic [WORD_BITS-1:0] bits;
        logic                 long_run;   // four bytes instead of one
        logic                 panel;
        logic                 dc;
        logic                 fin;
    } t_job;

    function automatic logic [PIX_BITS-1:0] pixel_code(input logic black, input logic red);
        logic [PIX_BITS-1:0] code;
        if (black) begin
            code = PIX_BLACK;
        end else if (red) begin
            code = PIX_RED;
        end else begin
            code = PIX_WHITE;
        end
        return code;
    endfunction

endpackage
`default_nettype wire

### design/epp_if.sv
// Interfaces: request channel and serial bit result channel.
`default_nettype none
interface epp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic       panel;
    logic [7:0] byte_value;
    logic [7:0] mono_plane;
    logic [7:0] red_plane;
    logic       final_item;

    modport source (output valid, cmd, panel, byte_value, mono_plane, red_plane, final_item,
                    input ready);
    modport sink   (input valid, cmd, panel, byte_value, mono_plane, red_plane, final_item,
                    output ready);
endinterface

interface epp_out_if;
    logic valid;
    logic ready;
    logic panel_sel;
    logic dc_level;
    logic mosi_bit;
    logic byte_end;
    logic last;
    logic transfer_end;

    modport source (output valid, panel_sel, dc_level, mosi_bit, byte_end, last, transfer_end,
                    input ready);
    modport sink   (input valid, panel_sel, dc_level, mosi_bit, byte_end, last, transfer_end,
                    output ready);
endinterface
`default_nettype wire

### design/epaper_plane_pack_serial_writer.sv
// Top level: e-paper serial writer, front classifier, request queue and bit shifter.
//
//  channel | dir | handshake               | payload
//  i_in    | in  | i_in.valid / i_in.ready | cmd, panel, byte_value, mono_plane, red_plane,
//          |     |                         | final_item
//  o_out   | out | o_out.valid/o_out.ready | panel_sel, dc_level, mosi_bit, byte_end, last,
//          |     |                         | transfer_end
//
// A command or data request gives 8 bit results, a pixel request 32, one per cycle from
// the back shifter while o_out.ready is high; runs follow each other without gaps while
// requests keep coming. Results leave through the front register, queue and back shifter.
// Requests with an unused code or an unfitted panel are taken and give nothing.
// Reset is synchronous, active low, and empties the front register, queue and shifter.
// A stalled output holds its result; requests are taken until the queue and front register are full.
`default_nettype none
module epaper_plane_pack_serial_writer #(
    parameter int PANEL_COUNT = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    epp_in_if.sink    i_in,
    epp_out_if.source o_out
);
    import epp_pkg::*;

    t_job front_job;
    logic front_valid;
    logic front_ready;
    t_job back_job;
    logic back_valid;
    logic back_ready;

    epp_front #(
        .PANEL_COUNT (PANEL_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_job       (front_job),
        .o_job_valid (front_valid),
        .i_job_ready (front_ready)
    );

    epp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (front_job),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .o_job        (back_job),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready)
    );

    epp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (back_job),
        .i_job_valid (back_valid),
        .o_job_ready (back_ready),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

### design/epp_front.sv
// Front stage: accepts requests, drops unusable ones, packs bytes or pixel planes into a bit word.
`default_nettype none
module epp_front #(
    parameter int PANEL_COUNT = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    epp_in_if.sink             i_in,
    output epp_pkg::t_job      o_job,
    output logic               o_job_valid,
    input  wire logic          i_job_ready
);
    import epp_pkg::*;

    logic  r_valid;
    t_job  r_job;
    t_job  n_job;
    logic  n_keep;
    logic  panel_ok;

    assign panel_ok   = (32'(i_in.panel) < 32'(PANEL_COUNT));
    assign i_in.ready = !r_valid || i_job_ready;

    always_comb begin
        n_job          = '0;
        n_job.panel    = i_in.panel;
        n_job.fin      = i_in.final_item;
        n_keep         = 1'b0;
        case (t_cmd'(i_in.cmd))
            CMD_COMMAND, CMD_DATA: begin
                n_keep         = panel_ok;
                n_job.dc       = (t_cmd'(i_in.cmd) == CMD_DATA);
                n_job.long_run = 1'b0;
                n_job.bits     = {i_in.byte_value, {(WORD_BITS-BYTE_BITS){1'b0}}};
            end
            CMD_PIXEL: begin
                n_keep         = panel_ok;
                n_job.dc       = 1'b1;
                n_job.long_run = 1'b1;
                // pixel i (msb first) lands in nibble i from the top
                for (int i = 0; i < PIX_COUNT; i++) begin
                    n_job.bits[WORD_BITS-1-PIX_BITS*i -: PIX_BITS] =
                        pixel_code(i_in.mono_plane[PIX_COUNT-1-i],
                                   i_in.red_plane[PIX_COUNT-1-i]);
                end
            end
            default: begin
                n_keep = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= n_keep;
        end else if (i_job_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_job <= n_job;
        end
    end

    assign o_job       = r_job;
    assign o_job_valid = r_valid;

endmodule
`default_nettype wire

### design/epp_queue.sv
// Two-entry queue of classified requests between front and back.
`default_nettype none
module epp_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire epp_pkg::t_job i_job,
    input  wire logic          i_push_valid,
    output logic               o_push_ready,
    output epp_pkg::t_job      o_job,
    output logic               o_pop_valid,
    input  wire logic          i_pop_ready
);
    import epp_pkg::*;

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_BITS = $clog2(DEPTH);

    t_job                r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [PTR_BITS:0]   r_count;
    logic                push;
    logic                pop;

    assign o_push_ready = (r_count < (PTR_BITS+1)'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop_ready && o_pop_valid;
    assign o_job        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule
`default_nettype wire

### design/epp_back.sv
// Back stage: shifts each queued request out msb first, one bit result per cycle unless stalled.
`default_nettype none
module epp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire epp_pkg::t_job i_job,
    input  wire logic          i_job_valid,
    output logic               o_job_ready,
    epp_out_if.source          o_out
);
    import epp_pkg::*;

    logic                  r_busy;
    logic [WORD_BITS-1:0]  r_word;
    logic [CNT_BITS-1:0]   r_cnt;
    logic                  r_long;
    logic                  r_panel;
    logic                  r_dc;
    logic                  r_fin;
    logic                  run_last;
    logic                  take;

    assign run_last    = r_long ? (r_cnt == CNT_WORD_LAST) : (r_cnt == CNT_BYTE_LAST);
    assign take        = o_out.valid && o_out.ready;
    assign o_job_ready = !r_busy || (take && run_last);

    assign o_out.valid        = r_busy;
    assign o_out.panel_sel    = r_panel;
    assign o_out.dc_level     = r_dc;
    assign o_out.mosi_bit     = r_word[WORD_BITS-1];
    assign o_out.byte_end     = (r_cnt[2:0] == CNT_BYTE_LAST[2:0]);
    assign o_out.last         = run_last;
    assign o_out.transfer_end = run_last && r_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_job_ready) begin
            r_busy <= i_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_ready && i_job_valid) begin
            r_word  <= i_job.bits;
            r_cnt   <= '0;
            r_long  <= i_job.long_run;
            r_panel <= i_job.panel;
            r_dc    <= i_job.dc;
            r_fin   <= i_job.fin;
        end else if (take) begin
            r_word <= {r_word[WORD_BITS-2:0], 1'b0};
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    a_last_ends_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.last |-> o_out.byte_end)
        else $error("run ended off a byte boundary");

    a_xfer_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.transfer_end |-> o_out.last)
        else $error("transfer end without run end");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !o_out.last |=> o_out.valid && $stable(o_out.panel_sel)
                                && $stable(o_out.dc_level))
        else $error("run broken before its last bit");

    a_command_one_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.dc_level && o_out.byte_end |-> o_out.last)
        else $error("command run longer than one byte");

endmodule
`default_nettype wire
